// ===== src/bts_pkg.sv =====
package bts_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam int unsigned AddrW     = XW + YW;
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned SizeW     = 9;

  typedef enum logic [2:0] {
    CfgWidth   = 3'd0,
    CfgHeight  = 3'd1,
    CfgClamp   = 3'd2,
    CfgPresent = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic [15:0]        red_in;
    logic [15:0]        green_in;
    logic [15:0]        blue_in;
  } in_item_t;

  typedef struct packed {
    logic [19:0] red_out;
    logic [19:0] green_out;
    logic [19:0] blue_out;
  } out_item_t;

endpackage

// ===== src/bilinear_texture_sampler_core.sv =====
// Bilinear texture sampler. A texel write or a lookup may be issued on every clock
// (busy_o stays low); for a lookup res_valid_o rises when the item leaves the last
// stage, with the result registered on res_o in that last stage; a write gives none.
// Throughput is one item per clock, set by the eight-stage pipeline with four read
// replicas of the 64K x 48 texel store, written and read in the same stage so items
// keep their order. Results cannot be held off: the receiver must take each one in its
// strobe cycle. Texels must be written before they are looked up; the store is not
// cleared by reset.
module bilinear_texture_sampler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  bts_pkg::in_item_t  item_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  output logic               res_valid_o,
  output bts_pkg::out_item_t res_o
);
  import bts_pkg::*;

  logic [SizeW-1:0] width_q, height_q, eff_w, eff_h;
  logic             clamp_q, present_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 9'd1;
      height_q  <= 9'd1;
      clamp_q   <= 1'b0;
      present_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWidth:   width_q   <= cfg_data_i;
        CfgHeight:  height_q  <= cfg_data_i;
        CfgClamp:   clamp_q   <= cfg_data_i[0];
        CfgPresent: present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_q;
    if (width_q == '0) eff_w = 9'd1;
    else if (width_q > SizeW'(MaxWidth)) eff_w = SizeW'(MaxWidth);
    eff_h = height_q;
    if (height_q == '0) eff_h = 9'd1;
    else if (height_q > SizeW'(MaxHeight)) eff_h = SizeW'(MaxHeight);
  end

  function automatic logic [7:0] clamp_idx(logic signed [26:0] k, logic [8:0] n);
    logic signed [26:0] lim;
    lim = $signed({18'd0, n}) - 27'sd1;
    if (k < 0) return 8'd0;
    else if (k > lim) return lim[7:0];
    else return k[7:0];
  endfunction

  function automatic logic [7:0] wrap_next(logic [7:0] i, logic [8:0] n);
    logic [8:0] nx;
    nx = {1'b0, i} + 9'd1;
    return (nx == n) ? 8'd0 : nx[7:0];
  endfunction

  logic [8:1] v_q;
  logic       acc;
  assign acc = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[7:1], acc};
  end

  // stage 1: input register
  in_item_t it1_q;
  logic     pr1_q;
  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    pr1_q <= present_q;
  end

  // stage 2: scale coordinates by the size
  logic signed [41:0] pu2_q, pv2_q;
  logic [24:0]        fu2_q, fv2_q;
  in_item_t           it2_q;
  logic               pr2_q;
  always_ff @(posedge clk_i) begin
    pu2_q <= it1_q.u_coord * $signed({1'b0, eff_w});
    pv2_q <= it1_q.v_coord * $signed({1'b0, eff_h});
    fu2_q <= it1_q.u_coord[15:0] * eff_w;
    fv2_q <= it1_q.v_coord[15:0] * eff_h;
    it2_q <= it1_q;
    pr2_q <= pr1_q;
  end

  // stage 3: fit indices, form addresses
  logic [AddrW-1:0] a3_q [4];
  logic [15:0]      s3_q, t3_q;
  in_item_t         it3_q;
  logic             pr3_q;
  logic [7:0]       i0, i1, j0, j1;
  logic signed [26:0] ki, kj;

  always_comb begin
    ki = 27'($signed(pu2_q[41:16]));
    kj = 27'($signed(pv2_q[41:16]));
    if (clamp_q) begin
      i0 = clamp_idx(ki, eff_w);
      i1 = clamp_idx(ki + 27'sd1, eff_w);
      j0 = clamp_idx(kj, eff_h);
      j1 = clamp_idx(kj + 27'sd1, eff_h);
    end else begin
      // u * w mod w*2^16 equals frac(u) * w, so the wrapped index falls out directly
      i0 = fu2_q[23:16];
      j0 = fv2_q[23:16];
      i1 = wrap_next(fu2_q[23:16], eff_w);
      j1 = wrap_next(fv2_q[23:16], eff_h);
    end
  end

  always_ff @(posedge clk_i) begin
    if (it2_q.kind) begin
      a3_q[0] <= {j0[YW-1:0], i0[XW-1:0]};
      a3_q[1] <= {j1[YW-1:0], i0[XW-1:0]};
      a3_q[2] <= {j0[YW-1:0], i1[XW-1:0]};
      a3_q[3] <= {j1[YW-1:0], i1[XW-1:0]};
    end else begin
      for (int k = 0; k < 4; k++) a3_q[k] <= {it2_q.texel_y, it2_q.texel_x};
    end
    s3_q  <= pu2_q[15:0];
    t3_q  <= pv2_q[15:0];
    it3_q <= it2_q;
    pr3_q <= pr2_q;
  end

  // stage 4: store access (read old data) and weights
  logic [47:0] mem_q [4][Depth];
  logic [47:0] tx4_q [4];
  logic [33:0] w4_q  [4];
  logic [15:0] sc4_q [3];
  logic        pr4_q;
  logic [16:0] s0, t0, s1, t1;
  logic        we3;

  assign s1  = {1'b0, s3_q};
  assign t1  = {1'b0, t3_q};
  assign s0  = 17'h10000 - s1;
  assign t0  = 17'h10000 - t1;
  assign we3 = v_q[3] && !it3_q.kind;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      tx4_q[k] <= mem_q[k][a3_q[k]];
      if (we3) mem_q[k][a3_q[k]] <= {it3_q.red_in, it3_q.green_in, it3_q.blue_in};
    end
    w4_q[0] <= s0 * t0;
    w4_q[1] <= s0 * t1;
    w4_q[2] <= s1 * t0;
    w4_q[3] <= s1 * t1;
    sc4_q[0] <= it3_q.red_in;
    sc4_q[1] <= it3_q.green_in;
    sc4_q[2] <= it3_q.blue_in;
    pr4_q    <= pr3_q;
  end

  // stage 5: texel times weight
  logic [49:0] p5_q [3][4];
  logic [15:0] sc5_q [3];
  logic        pr5_q;
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        p5_q[c][k] <= tx4_q[k][47-16*c -: 16] * w4_q[k];
      end
    end
    sc5_q <= sc4_q;
    pr5_q <= pr4_q;
  end

  // stage 6: blend sum, below 2^48 since the weights total 2^32
  logic [47:0] b6_q [3];
  logic [15:0] sc6_q [3];
  logic        pr6_q;
  logic [49:0] sum6 [3];
  always_comb begin
    for (int c = 0; c < 3; c++) sum6[c] = p5_q[c][0] + p5_q[c][1] + p5_q[c][2] + p5_q[c][3];
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) b6_q[c] <= sum6[c][47:0];
    sc6_q <= sc5_q;
    pr6_q <= pr5_q;
  end

  // stage 7: scale product in two halves
  logic [39:0] lo7_q [3], hi7_q [3];
  logic [15:0] sc7_q [3];
  logic        pr7_q;
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      lo7_q[c] <= b6_q[c][23:0] * sc6_q[c];
      hi7_q[c] <= b6_q[c][47:24] * sc6_q[c];
    end
    sc7_q <= sc6_q;
    pr7_q <= pr6_q;
  end

  // stage 8: combine, floor to Q8.12
  logic [63:0] tot8 [3];
  logic [19:0] ch8  [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot8[c] = {hi7_q[c], 24'd0} + {24'd0, lo7_q[c]};
      ch8[c]  = pr7_q ? tot8[c][63:44] : {4'd0, sc7_q[c]};
    end
  end
  always_ff @(posedge clk_i) begin
    res_o.red_out   <= ch8[0];
    res_o.green_out <= ch8[1];
    res_o.blue_out  <= ch8[2];
  end

  logic kind8_q, kind7_q, kind6_q, kind5_q, kind4_q;
  always_ff @(posedge clk_i) begin
    kind4_q <= it3_q.kind;
    kind5_q <= kind4_q;
    kind6_q <= kind5_q;
    kind7_q <= kind6_q;
    kind8_q <= kind7_q;
  end
  assign res_valid_o = v_q[8] && kind8_q;

  a_lookup_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.kind) |-> ##8 res_valid_o)
    else $error("lookup result missing");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !item_i.kind) |-> ##8 !res_valid_o)
    else $error("write produced a result");

  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && it3_q.kind && !clamp_q) |-> (a3_q[0][XW-1:0] < eff_w[XW:0]))
    else $error("wrapped column out of range");

endmodule

// ===== dv/tb_bilinear_texture_sampler_core.sv =====
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler_core;
  import bts_pkg::*;

  localparam logic       KindWrite  = 1'b0;
  localparam logic       KindLookup = 1'b1;
  localparam logic [2:0] CfgUnused  = 3'd7;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic       busy_o;
  in_item_t   item_i      = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i  = '0;
  logic       res_valid_o;
  out_item_t  res_o;

  bilinear_texture_sampler_core uut (.*);

  // mirror of the block's registers and texel store
  logic [8:0]  tex_w = 9'd1, tex_h = 9'd1;
  logic        clamp_on = 1'b0, tex_on = 1'b0;
  logic [47:0] texel_mem [0:65535];
  bit          texel_planned [0:65535];

  in_item_t  pending_items [$];
  out_item_t expected_pixels [$];
  int        n_errors = 0;
  int        gap = 0;
  bit        no_gaps = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint eff_size(logic [8:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return longint'(r);
  endfunction

  function automatic longint fit_index(longint k, longint n);
    longint r;
    if (clamp_on) return (k < 0) ? 0 : (k > n - 1) ? n - 1 : k;
    r = k % n;
    if (r < 0) r += n;
    return r;
  endfunction

  // neighbour addresses 00, 01, 10, 11 (first digit: column step) and weights
  function automatic void neighbours(input logic signed [31:0] u, v,
                                     output int addr [4], output longint s, t);
    longint w, h, pu, pv, i0, j0, i1, j1;
    w  = eff_size(tex_w);
    h  = eff_size(tex_h);
    pu = longint'(u) * w;
    pv = longint'(v) * h;
    s  = pu & 64'hFFFF;
    t  = pv & 64'hFFFF;
    i0 = pu >>> 16;
    j0 = pv >>> 16;
    i1 = fit_index(i0 + 1, w);
    j1 = fit_index(j0 + 1, h);
    i0 = fit_index(i0, w);
    j0 = fit_index(j0, h);
    addr[0] = int'(j0 * 256 + i0);
    addr[1] = int'(j1 * 256 + i0);
    addr[2] = int'(j0 * 256 + i1);
    addr[3] = int'(j1 * 256 + i1);
  endfunction

  function automatic out_item_t filter_pixel(in_item_t it);
    out_item_t   o;
    int          a [4];
    longint      s, t;
    logic [127:0] acc, wgt [4];
    logic [15:0] scale [3];
    logic [19:0] chan [3];
    scale = '{it.red_in, it.green_in, it.blue_in};
    if (!tex_on) begin
      o.red_out   = {4'd0, it.red_in};
      o.green_out = {4'd0, it.green_in};
      o.blue_out  = {4'd0, it.blue_in};
      return o;
    end
    neighbours(it.u_coord, it.v_coord, a, s, t);
    wgt[0] = 128'(65536 - s) * 128'(65536 - t);
    wgt[1] = 128'(65536 - s) * 128'(t);
    wgt[2] = 128'(s) * 128'(65536 - t);
    wgt[3] = 128'(s) * 128'(t);
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int k = 0; k < 4; k++)
        acc += 128'(texel_mem[a[k]][47 - 16*c -: 16]) * wgt[k];
      acc = (acc * 128'(scale[c])) >> 44;
      chan[c] = acc[19:0];
    end
    o.red_out   = chan[0];
    o.green_out = chan[1];
    o.blue_out  = chan[2];
    return o;
  endfunction

  // driver: one transaction per accepted edge, random gap drawn per item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap     <= 0;
    end else begin
      if (start_i && !busy_o) begin
        if (item_i.kind == KindWrite)
          texel_mem[{item_i.texel_y, item_i.texel_x}] =
            {item_i.red_in, item_i.green_in, item_i.blue_in};
        else
          expected_pixels = {expected_pixels, filter_pixel(item_i)};
      end
      if (!(start_i && busy_o)) begin
        if (gap != 0) begin
          gap     <= gap - 1;
          start_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_i  <= pending_items.pop_front();
          start_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) no_gaps = ~no_gaps;
          gap     <= no_gaps ? 0 : $urandom_range(0, 16);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, res_o);
        n_errors++;
      end else begin
        out_item_t e;
        e = expected_pixels.pop_front();
        if (res_o.red_out !== e.red_out) begin
          $display("%0t: red expected %h actual %h", $time, e.red_out, res_o.red_out);
          n_errors++;
        end
        if (res_o.green_out !== e.green_out) begin
          $display("%0t: green expected %h actual %h", $time, e.green_out,
                   res_o.green_out);
          n_errors++;
        end
        if (res_o.blue_out !== e.blue_out) begin
          $display("%0t: blue expected %h actual %h", $time, e.blue_out,
                   res_o.blue_out);
          n_errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgWidth:   tex_w    = val;
      CfgHeight:  tex_h    = val;
      CfgClamp:   clamp_on = val[0];
      CfgPresent: tex_on   = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start_i || expected_pixels.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic queue_write(logic [7:0] x, y, logic [47:0] rgb);
    in_item_t it;
    it = '0;
    it.kind     = KindWrite;
    it.texel_x  = x;
    it.texel_y  = y;
    it.u_coord  = $urandom;
    it.v_coord  = $urandom;
    {it.red_in, it.green_in, it.blue_in} = rgb;
    texel_planned[{y, x}] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [47:0] rand_rgb();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // with the texture on, writes any neighbour not yet loaded; then issues the lookup
  task automatic queue_lookup(logic signed [31:0] u, v, logic [47:0] scale);
    in_item_t it;
    int       a [4];
    longint   s, t;
    if (tex_on) begin
      neighbours(u, v, a, s, t);
      for (int k = 0; k < 4; k++)
        if (!texel_planned[a[k]]) queue_write(a[k][7:0], a[k][15:8], rand_rgb());
    end
    it = '0;
    it.kind    = KindLookup;
    it.texel_x = $urandom;
    it.texel_y = $urandom;
    it.u_coord = u;
    it.v_coord = v;
    {it.red_in, it.green_in, it.blue_in} = scale;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
      2: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 2)),
                 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [8:0] sizes [8][3];
    sizes = '{'{9'd1, 9'd1, 9'd0}, '{9'd0, 9'd0, 9'd1}, '{9'd256, 9'd256, 9'd0},
              '{9'd256, 9'd256, 9'd1}, '{9'd511, 9'd300, 9'd0}, '{9'd3, 9'd5, 9'd1},
              '{9'd7, 9'd2, 9'd0}, '{9'd0, 9'd0, 9'd0}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no texture: lookup hands back the scale; writes still land in the store
    queue_write(8'd0, 8'd0, 48'hFFFF_FFFF_FFFF);
    queue_write(8'd255, 8'd255, 48'h0);
    queue_lookup(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_lookup(32'h7FFF_FFFF, 32'h8000_0000, 48'h0);
    queue_lookup(32'h0, 32'h0, 48'h1234_5678_9ABC);
    wait_idle();

    write_reg(CfgPresent, 9'd1);
    write_reg(CfgUnused, 9'h1FF);
    write_reg(CfgWidth, 9'd256);
    write_reg(CfgHeight, 9'd256);
    write_reg(CfgClamp, 9'd0);
    // extremes of coordinate, weight and scale
    queue_lookup(32'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
    queue_lookup(32'h0000_FFFF, 32'h0000_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_lookup(32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    queue_lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h1000_1000_1000);
    queue_lookup(32'hFFFF_FFFF, 32'h0001_0000, 48'h0);
    wait_idle();
    write_reg(CfgClamp, 9'd1);
    queue_lookup(32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_lookup(32'h0001_0000, 32'h8000_0000, 48'h1000_1000_1000);
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      int sel;
      sel = ph < 8 ? ph : $urandom_range(0, 7);
      if (ph >= 8 && $urandom_range(0, 1)) begin
        write_reg(CfgWidth, 9'($urandom_range(0, 511)));
        write_reg(CfgHeight, 9'($urandom_range(0, 511)));
        write_reg(CfgClamp, 9'($urandom_range(0, 1)));
      end else begin
        write_reg(CfgWidth, sizes[sel][0]);
        write_reg(CfgHeight, sizes[sel][1]);
        write_reg(CfgClamp, sizes[sel][2]);
      end
      write_reg(CfgPresent, (ph % 5 == 4) ? 9'd0 : 9'd1);
      for (int n = 0; n < 10; n++) begin
        if ($urandom_range(0, 4) == 0)
          queue_write(8'($urandom), 8'($urandom), rand_rgb());
        else
          queue_lookup(rand_coord(), rand_coord(), rand_rgb());
      end
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
